@@ design/tga_pkg.sv @@
package tga_pkg;

  localparam int PHASE_BITS_DEF = 12;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] REG_CENTER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AMP    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TURN   = 2'd3;

  localparam logic [7:0]  CENTER_RST = 8'd90;
  localparam logic [6:0]  AMP_RST    = 7'd30;
  localparam logic [11:0] STEP_RST   = 12'd82;
  localparam logic [8:0]  TURN_RST   = 9'd51;
  localparam logic [8:0]  FULL_SWING = 9'd256;

  localparam logic [2:0] MODE_STOP  = 3'd0;
  localparam logic [2:0] MODE_FWD   = 3'd1;
  localparam logic [2:0] MODE_BACK  = 3'd2;
  localparam logic [2:0] MODE_LEFT  = 3'd3;
  localparam logic [2:0] MODE_RIGHT = 3'd4;

  localparam logic [7:0] ANGLE_MAX = 8'd180;

  localparam int MUL_W      = 17;
  localparam int PROD_W     = 2 * MUL_W;
  localparam int FRAC_SHIFT = 23;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INTERP,
    S_SINE,
    S_AMP_L,
    S_AMP_R,
    S_SW_L,
    S_SW_R,
    S_LEGS,
    S_DONE
  } tga_state_t;

  function automatic logic [14:0] quarter_sine(input logic [6:0] idx);
    logic [14:0] v;
    case (idx)
      7'd0:  v = 15'd0;     7'd1:  v = 15'd804;   7'd2:  v = 15'd1608;
      7'd3:  v = 15'd2410;  7'd4:  v = 15'd3212;  7'd5:  v = 15'd4011;
      7'd6:  v = 15'd4808;  7'd7:  v = 15'd5602;  7'd8:  v = 15'd6393;
      7'd9:  v = 15'd7179;  7'd10: v = 15'd7962;  7'd11: v = 15'd8739;
      7'd12: v = 15'd9512;  7'd13: v = 15'd10278; 7'd14: v = 15'd11039;
      7'd15: v = 15'd11793; 7'd16: v = 15'd12539; 7'd17: v = 15'd13279;
      7'd18: v = 15'd14010; 7'd19: v = 15'd14732; 7'd20: v = 15'd15446;
      7'd21: v = 15'd16151; 7'd22: v = 15'd16846; 7'd23: v = 15'd17530;
      7'd24: v = 15'd18204; 7'd25: v = 15'd18868; 7'd26: v = 15'd19519;
      7'd27: v = 15'd20159; 7'd28: v = 15'd20787; 7'd29: v = 15'd21403;
      7'd30: v = 15'd22005; 7'd31: v = 15'd22594; 7'd32: v = 15'd23170;
      7'd33: v = 15'd23731; 7'd34: v = 15'd24279; 7'd35: v = 15'd24811;
      7'd36: v = 15'd25329; 7'd37: v = 15'd25832; 7'd38: v = 15'd26319;
      7'd39: v = 15'd26790; 7'd40: v = 15'd27245; 7'd41: v = 15'd27683;
      7'd42: v = 15'd28105; 7'd43: v = 15'd28510; 7'd44: v = 15'd28898;
      7'd45: v = 15'd29268; 7'd46: v = 15'd29621; 7'd47: v = 15'd29956;
      7'd48: v = 15'd30273; 7'd49: v = 15'd30571; 7'd50: v = 15'd30852;
      7'd51: v = 15'd31113; 7'd52: v = 15'd31356; 7'd53: v = 15'd31580;
      7'd54: v = 15'd31785; 7'd55: v = 15'd31971; 7'd56: v = 15'd32137;
      7'd57: v = 15'd32285; 7'd58: v = 15'd32412; 7'd59: v = 15'd32521;
      7'd60: v = 15'd32609; 7'd61: v = 15'd32678; 7'd62: v = 15'd32728;
      7'd63: v = 15'd32757; 7'd64: v = 15'd32767;
      default: v = 15'd0;
    endcase
    return v;
  endfunction

endpackage

@@ design/tga_mul.sv @@
module tga_mul (
  input  logic                              clk,
  input  logic signed [tga_pkg::MUL_W-1:0]  mul_a,
  input  logic signed [tga_pkg::MUL_W-1:0]  mul_b,
  output logic signed [tga_pkg::PROD_W-1:0] prod_r
);
  import tga_pkg::*;

  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(mul_a) * PROD_W'(mul_b);
  end

endmodule

@@ design/trot_gait_angle_generator.sv @@
// Trot gait angle generator: each accepted word is one gait tick that may carry a motion
// command (0 stop, 1 forward, 2 backward, 3 left, 4 right, anything larger stops), and it
// returns one word with four servo angles (0..180 degrees) and the mode in force. A tick in
// a moving mode runs from acceptance to the result register through one interpolation
// multiply for the sine, two amplitude-by-side-factor multiplies, two swing multiplies and
// one capture step, all on one shared 17x17 multiplier, then through the four legs in turn
// on one shared add/round/saturate unit, and then the load of the result. A tick in stop
// goes straight from acceptance to the result load. Each load returns to idle, and a new
// tick is taken only from idle, so the block never takes a new tick before the last is
// loaded. The input stalls while a tick is in work and while a finished tick waits for a
// full output register; a finished word waits in the output register and a new tick may be
// taken meanwhile. The phase advances by step_r after each moving tick and holds in stop.
module trot_gait_angle_generator #(
  parameter int PHASE_BITS = tga_pkg::PHASE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_command_valid,
  input  logic [7:0]                         in_mode,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [7:0]                         out_front_left_angle,
  output logic [7:0]                         out_front_right_angle,
  output logic [7:0]                         out_back_left_angle,
  output logic [7:0]                         out_back_right_angle,
  output logic [2:0]                         out_current_mode,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [tga_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tga_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import tga_pkg::*;

  localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) <<< (FRAC_SHIFT - 1);

  tga_state_t state_r, state_nxt;

  logic [7:0]            center_r;
  logic [6:0]            amp_r;
  logic [11:0]           step_r;
  logic [8:0]            turn_r;
  logic [2:0]            mode_r, mode_nxt;
  logic [PHASE_BITS-1:0] phase_r, phase_nxt;
  logic [1:0]            leg_cnt_r, leg_cnt_nxt;

  logic signed [15:0]    sine_r, sine_nxt;
  logic [15:0]           af_l_r, af_l_nxt;
  logic [15:0]           af_r_r, af_r_nxt;
  logic signed [31:0]    sw_l_r, sw_l_nxt;
  logic signed [31:0]    sw_r_r, sw_r_nxt;
  logic [7:0]            leg_ang_r [4];
  logic [7:0]            leg_ang_nxt [4];

  logic                  out_valid_r, out_valid_nxt;
  logic [7:0]            out_fl_r, out_fl_nxt;
  logic [7:0]            out_fr_r, out_fr_nxt;
  logic [7:0]            out_bl_r, out_bl_nxt;
  logic [7:0]            out_br_r, out_br_nxt;
  logic [2:0]            out_mode_r, out_mode_nxt;

  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod_r;

  logic [15:0]        p16;
  logic [1:0]         quad;
  logic [14:0]        r_fold;
  logic [6:0]         tbl_idx;
  logic [7:0]         tbl_frac;
  logic [14:0]        tbl_lo, tbl_hi, tbl_diff, sine_mag;
  logic [8:0]         fac_l, fac_r;
  logic [7:0]         center_sat;
  logic [2:0]         cmd_mode;
  logic signed [31:0] sw_sel;
  logic               leg_neg;
  logic signed [PROD_W-1:0] leg_acc;
  logic [PROD_W-FRAC_SHIFT-1:0] leg_deg;
  logic [7:0]         leg_sat;

  tga_mul u_mul (
    .clk    (clk),
    .mul_a  (mul_a),
    .mul_b  (mul_b),
    .prod_r (prod_r)
  );

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != S_IDLE);

  assign out_valid             = out_valid_r;
  assign out_front_left_angle  = out_fl_r;
  assign out_front_right_angle = out_fr_r;
  assign out_back_left_angle   = out_bl_r;
  assign out_back_right_angle  = out_br_r;
  assign out_current_mode      = out_mode_r;

  always_comb begin
    p16      = 16'(phase_r) << (16 - PHASE_BITS);
    quad     = p16[15:14];
    r_fold   = quad[0] ? (15'h4000 - {1'b0, p16[13:0]}) : {1'b0, p16[13:0]};
    tbl_idx  = r_fold[14:8];
    tbl_frac = r_fold[7:0];
    tbl_lo   = quarter_sine(tbl_idx);
    tbl_hi   = (tbl_idx < 7'd64) ? quarter_sine(tbl_idx + 7'd1) : tbl_lo;
    tbl_diff = tbl_hi - tbl_lo;
    sine_mag = tbl_lo + 15'(prod_r[17:8]);

    fac_l      = (mode_r == MODE_LEFT)  ? turn_r : FULL_SWING;
    fac_r      = (mode_r == MODE_RIGHT) ? turn_r : FULL_SWING;
    center_sat = (center_r > ANGLE_MAX) ? ANGLE_MAX : center_r;
    cmd_mode   = (in_mode <= 8'(MODE_RIGHT)) ? in_mode[2:0] : MODE_STOP;

    sw_sel  = leg_cnt_r[0] ? sw_r_r : sw_l_r;
    leg_neg = (leg_cnt_r[0] ^ leg_cnt_r[1]) ^ (mode_r == MODE_BACK);
    leg_acc = PROD_W'({center_r, {FRAC_SHIFT{1'b0}}}) + ROUND_HALF
            + (leg_neg ? -PROD_W'(sw_sel) : PROD_W'(sw_sel));
    leg_deg = leg_acc[PROD_W-1:FRAC_SHIFT];
    if (leg_acc[PROD_W-1]) begin
      leg_sat = 8'd0;
    end else if (leg_deg > (PROD_W-FRAC_SHIFT)'(ANGLE_MAX)) begin
      leg_sat = ANGLE_MAX;
    end else begin
      leg_sat = leg_deg[7:0];
    end
  end

  always_comb begin
    state_nxt    = state_r;
    mode_nxt     = mode_r;
    phase_nxt    = phase_r;
    leg_cnt_nxt  = leg_cnt_r;
    sine_nxt     = sine_r;
    af_l_nxt     = af_l_r;
    af_r_nxt     = af_r_r;
    sw_l_nxt     = sw_l_r;
    sw_r_nxt     = sw_r_r;
    leg_ang_nxt  = leg_ang_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_fl_nxt   = out_fl_r;
    out_fr_nxt   = out_fr_r;
    out_bl_nxt   = out_bl_r;
    out_br_nxt   = out_br_r;
    out_mode_nxt = out_mode_r;
    mul_a        = '0;
    mul_b        = '0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_command_valid) begin
            mode_nxt = cmd_mode;
          end
          if ((in_command_valid ? cmd_mode : mode_r) == MODE_STOP) begin
            for (int i = 0; i < 4; i++) begin
              leg_ang_nxt[i] = center_sat;
            end
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_INTERP;
          end
        end
      end
      S_INTERP: begin
        mul_a     = MUL_W'(tbl_diff);
        mul_b     = MUL_W'(tbl_frac);
        state_nxt = S_SINE;
      end
      S_SINE: begin
        sine_nxt  = quad[1] ? -16'(sine_mag) : 16'(sine_mag);
        mul_a     = MUL_W'(amp_r);
        mul_b     = MUL_W'(fac_l);
        state_nxt = S_AMP_L;
      end
      S_AMP_L: begin
        af_l_nxt  = prod_r[15:0];
        mul_a     = MUL_W'(amp_r);
        mul_b     = MUL_W'(fac_r);
        state_nxt = S_AMP_R;
      end
      S_AMP_R: begin
        af_r_nxt  = prod_r[15:0];
        mul_a     = MUL_W'(af_l_r);
        mul_b     = MUL_W'(sine_r);
        state_nxt = S_SW_L;
      end
      S_SW_L: begin
        sw_l_nxt  = prod_r[31:0];
        mul_a     = MUL_W'(af_r_r);
        mul_b     = MUL_W'(sine_r);
        state_nxt = S_SW_R;
      end
      S_SW_R: begin
        sw_r_nxt    = prod_r[31:0];
        leg_cnt_nxt = 2'd0;
        state_nxt   = S_LEGS;
      end
      S_LEGS: begin
        leg_ang_nxt[leg_cnt_r] = leg_sat;
        leg_cnt_nxt = leg_cnt_r + 2'd1;
        if (leg_cnt_r == 2'd3) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_fl_nxt    = leg_ang_r[0];
          out_fr_nxt    = leg_ang_r[1];
          out_bl_nxt    = leg_ang_r[2];
          out_br_nxt    = leg_ang_r[3];
          out_mode_nxt  = mode_r;
          if (mode_r != MODE_STOP) begin
            phase_nxt = phase_r + PHASE_BITS'(step_r);
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mode_r      <= MODE_STOP;
      phase_r     <= '0;
      out_valid_r <= 1'b0;
      center_r    <= CENTER_RST;
      amp_r       <= AMP_RST;
      step_r      <= STEP_RST;
      turn_r      <= TURN_RST;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          REG_CENTER: center_r <= cfg_data[7:0];
          REG_AMP:    amp_r    <= cfg_data[6:0];
          REG_STEP:   step_r   <= cfg_data[11:0];
          REG_TURN:   turn_r   <= cfg_data[8:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    leg_cnt_r  <= leg_cnt_nxt;
    sine_r     <= sine_nxt;
    af_l_r     <= af_l_nxt;
    af_r_r     <= af_r_nxt;
    sw_l_r     <= sw_l_nxt;
    sw_r_r     <= sw_r_nxt;
    leg_ang_r  <= leg_ang_nxt;
    out_fl_r   <= out_fl_nxt;
    out_fr_r   <= out_fr_nxt;
    out_bl_r   <= out_bl_nxt;
    out_br_r   <= out_br_nxt;
    out_mode_r <= out_mode_nxt;
  end

`ifndef ASSERT_OFF
  a_accept_starts_work: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r != S_IDLE))
    else $error("accepted tick did not start work");

  a_phase_moves_only_at_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_DONE) |=> $stable(phase_r))
    else $error("phase changed outside result load");

  a_angles_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_fl_r <= ANGLE_MAX && out_fr_r <= ANGLE_MAX &&
                     out_bl_r <= ANGLE_MAX && out_br_r <= ANGLE_MAX))
    else $error("servo angle out of range");

  a_stop_holds_center: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && mode_r == MODE_STOP) |->
      (leg_ang_r[0] == center_sat && leg_ang_r[3] == center_sat))
    else $error("stop tick not at center");
`endif

endmodule
